// ===== hw/rtl/psis_pkg.sv =====
`default_nettype none

package psis_pkg;

	// Result status codes
	localparam logic [1:0] ST_RECORDED  = 2'd0;
	localparam logic [1:0] ST_ALLOCATED = 2'd1;
	localparam logic [1:0] ST_REFUSED   = 2'd2;
	localparam logic [1:0] ST_IGNORED   = 2'd3;

	// Input mode codes
	localparam logic MODE_ALLOC  = 1'b0;
	localparam logic MODE_RECORD = 1'b1;

	localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

	typedef struct packed {
		logic        mode;
		logic [3:0]  slot_index;
		logic [63:0] start_time;
		logic [63:0] now_time;
	} item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [3:0]  result_index;
		logic [31:0] sample_count;
		logic [63:0] total_time;
		logic [63:0] min_time;
		logic [63:0] max_time;
	} result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/per_slot_interval_statistics_core.sv =====
`default_nettype none

// Per-slot interval statistics core.
// Command beats are presented on item with start; a beat is taken at a clock
// edge where start is high and busy is low. busy is always low, so one beat
// may be taken in every cycle.
// An allocate beat claims the next free slot and clears it; a record beat
// folds (now_time - start_time, floored at zero) into the named slot's count,
// total, minimum and maximum.
// Each beat gives exactly one result beat on result, marked by done for a
// single cycle: the elapsed time is formed on the way into the input
// register, the slot update and result are formed between the input register
// and the result register.
// Sustained throughput is one beat per cycle; the slot table is a flop array
// read and written once per cycle, so back-to-back beats to one slot see
// each other's updates.
// The receiver cannot stall: done is a pulse and must be taken that cycle.
// Reset clears the allocation count and all valid flags; no result is given
// until a beat is taken. Slot contents are not reset; allocation clears a slot.
module per_slot_interval_statistics_core #(
	parameter int NUM_SLOTS = 16
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              start,
	output logic             busy,
	input  psis_pkg::item_t  item,
	output logic             done,
	output psis_pkg::result_t result
);
	import psis_pkg::*;

	localparam int UW    = $clog2(NUM_SLOTS + 1);
	localparam int DEPTH = (NUM_SLOTS < 16) ? NUM_SLOTS : 16;
	localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CMPW  = (UW > 4) ? UW : 4;

	// Slot table; only slots reachable by a 4-bit index are stored
	logic [31:0] cnt_q   [DEPTH];
	logic [63:0] total_q [DEPTH];
	logic [63:0] min_q   [DEPTH];
	logic [63:0] max_q   [DEPTH];

	logic [UW-1:0] used_q;

	// Input stage
	logic        v_s1;
	logic        mode_s1;
	logic [3:0]  idx_s1;
	logic [63:0] elapsed_s1;

	logic [63:0] elapsed_d;

	// Output register
	logic    done_q;
	result_t res_q;

	// Next-state of the addressed slot
	logic          full;
	logic          idx_ok;
	logic          alloc_wr;
	logic          rec_wr;
	logic [IW-1:0] rd_idx;
	logic [IW-1:0] alloc_idx;
	logic [31:0]   cnt_rd;
	logic [63:0]   total_rd;
	logic [63:0]   min_rd;
	logic [63:0]   max_rd;
	logic [31:0]   cnt_nx;
	logic [63:0]   total_nx;
	logic [63:0]   min_nx;
	logic [63:0]   max_nx;
	result_t       res_d;

	assign busy   = 1'b0;
	assign done   = done_q;
	assign result = res_q;

	// Elapsed time, floored at zero
	assign elapsed_d = (item.now_time > item.start_time) ?
		(item.now_time - item.start_time) : 64'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			mode_s1    <= item.mode;
			idx_s1     <= item.slot_index;
			elapsed_s1 <= elapsed_d;
		end
	end

	// Decode and slot read
	assign full      = (used_q == UW'(NUM_SLOTS));
	assign idx_ok    = CMPW'(idx_s1) < CMPW'(used_q);
	assign rd_idx    = idx_s1[IW-1:0];
	assign alloc_idx = used_q[IW-1:0];
	assign alloc_wr  = v_s1 && (mode_s1 == MODE_ALLOC) && !full
		&& (CMPW'(used_q) < CMPW'(DEPTH));
	assign rec_wr    = v_s1 && (mode_s1 == MODE_RECORD) && idx_ok;

	assign cnt_rd   = cnt_q[rd_idx];
	assign total_rd = total_q[rd_idx];
	assign min_rd   = min_q[rd_idx];
	assign max_rd   = max_q[rd_idx];

	// Statistics update
	always_comb begin
		cnt_nx   = (cnt_rd != COUNT_MAX) ? (cnt_rd + 32'd1) : cnt_rd;
		total_nx = total_rd + elapsed_s1;
		min_nx   = ((cnt_rd == 32'd0) || (elapsed_s1 < min_rd)) ? elapsed_s1 : min_rd;
		max_nx   = (elapsed_s1 > max_rd) ? elapsed_s1 : max_rd;
	end

	// Result formation
	always_comb begin
		res_d = '0;
		if (mode_s1 == MODE_ALLOC) begin
			if (full) begin
				res_d.status = ST_REFUSED;
			end else begin
				res_d.status       = ST_ALLOCATED;
				res_d.result_index = 4'(used_q);
			end
		end else if (idx_ok) begin
			res_d.status       = ST_RECORDED;
			res_d.result_index = idx_s1;
			res_d.sample_count = cnt_nx;
			res_d.total_time   = total_nx;
			res_d.min_time     = min_nx;
			res_d.max_time     = max_nx;
		end else begin
			res_d.status = ST_IGNORED;
		end
	end

	// Allocation count and done flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= v_s1;
			if (v_s1 && (mode_s1 == MODE_ALLOC) && !full) begin
				used_q <= used_q + UW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			res_q <= res_d;
		end
	end

	// Slot table write
	always_ff @(posedge clk) begin
		if (alloc_wr) begin
			cnt_q[alloc_idx]   <= '0;
			total_q[alloc_idx] <= '0;
			min_q[alloc_idx]   <= '0;
			max_q[alloc_idx]   <= '0;
		end else if (rec_wr) begin
			cnt_q[rd_idx]   <= cnt_nx;
			total_q[rd_idx] <= total_nx;
			min_q[rd_idx]   <= min_nx;
			max_q[rd_idx]   <= max_nx;
		end
	end

	// Checks
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CMPW'(used_q) <= CMPW'(NUM_SLOTS))
		else $error("allocation count beyond table size");

	a_refuse_full: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && (res_q.status == ST_REFUSED) |-> full)
		else $error("refusal with free slots");

	a_alloc_step: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && (res_q.status == ST_ALLOCATED) |->
			(used_q == $past(used_q) + UW'(1)))
		else $error("allocation did not advance count");

	a_rec_order: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && (res_q.status == ST_RECORDED) |->
			(res_q.min_time <= res_q.max_time) && (res_q.sample_count != 32'd0))
		else $error("recorded statistics inconsistent");

endmodule

`default_nettype wire
